/* src/snne_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snne_pkg
// shared types and codes of the sparse network evaluator
// ----------------------------------------------------------------------------
package snne_pkg;

  // request kinds
  localparam logic [2:0] REQ_LINK     = 3'd0;
  localparam logic [2:0] REQ_RANGE    = 3'd1;
  localparam logic [2:0] REQ_SENSOR   = 3'd2;
  localparam logic [2:0] REQ_ACTIVATE = 3'd3;
  localparam logic [2:0] REQ_CLEAR    = 3'd4;
  localparam logic [2:0] REQ_READ     = 3'd5;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_ORDER = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_BIAS  = 2'd0;
  localparam logic [1:0] CFG_INPUT = 2'd1;
  localparam logic [1:0] CFG_NODES = 2'd2;

  // q4.12 one
  localparam logic signed [15:0] Q_ONE = 16'sd4096;

  // width of node counters, holds up to the largest node count
  localparam int CW = 13;

  typedef struct packed {
    logic [CW-1:0] nc;
    logic [CW-1:0] ic;
    logic [CW-1:0] bc;
  } cnt_t;

  typedef struct packed {
    logic [2:0]         req;
    logic [1:0]         status;
    logic [11:0]        index;
    logic [7:0]         source;
    logic signed [15:0] weight;
    logic [12:0]        rstart;
    logic [12:0]        rend;
    logic signed [15:0] sensor;
  } cmd_t;

endpackage
`default_nettype wire

/* src/snne_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snne_front
// request intake: decode, range checks and a two-entry command queue
// ----------------------------------------------------------------------------
module snne_front #(
  parameter int MAX_NODES = 256,
  parameter int MAX_LINKS = 4096
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire snne_pkg::cnt_t cnt,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [79:0]    in_tdata,
  input  wire logic [2:0]     in_tuser,
  output logic                cmd_valid,
  output snne_pkg::cmd_t      cmd,
  input  wire logic           cmd_pop
);

  snne_pkg::cmd_t dec;
  snne_pkg::cmd_t q_r [2];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           push, drop;

  always_comb begin
    dec.req    = in_tuser;
    dec.index  = in_tdata[11:0];
    dec.source = in_tdata[19:12];
    dec.weight = in_tdata[35:20];
    dec.rstart = in_tdata[48:36];
    dec.rend   = in_tdata[61:49];
    dec.sensor = in_tdata[77:62];
    dec.status = snne_pkg::STAT_OK;
    drop       = 1'b0;
    case (in_tuser)
      snne_pkg::REQ_LINK: begin
        if (32'(dec.index) >= MAX_LINKS || 32'(dec.source) >= MAX_NODES)
          dec.status = snne_pkg::STAT_RANGE;
      end
      snne_pkg::REQ_RANGE: begin
        if (32'(dec.index) >= MAX_NODES || 32'(dec.rend) > MAX_LINKS)
          dec.status = snne_pkg::STAT_RANGE;
        else if (dec.rstart > dec.rend)
          dec.status = snne_pkg::STAT_ORDER;
      end
      snne_pkg::REQ_SENSOR: begin
        if (32'(cnt.bc) + 32'(dec.index) >= 32'(cnt.ic))
          dec.status = snne_pkg::STAT_RANGE;
      end
      snne_pkg::REQ_READ: begin
        if (32'(dec.index) >= 32'(cnt.nc))
          dec.status = snne_pkg::STAT_RANGE;
      end
      snne_pkg::REQ_ACTIVATE, snne_pkg::REQ_CLEAR: begin
      end
      default: begin
        drop = 1'b1;
      end
    endcase
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready && !drop;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= dec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (cmd_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule
`default_nettype wire

/* src/snne_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snne_back
// executes queued requests: memories, multiply-accumulate pipe, tanh, results
// ----------------------------------------------------------------------------
module snne_back #(
  parameter int MAX_NODES       = 256,
  parameter int MAX_LINKS       = 4096,
  parameter int PASSES          = 1,
  parameter int TANH_TABLE_BITS = 10
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire snne_pkg::cnt_t cnt,
  input  wire logic           cmd_valid,
  input  wire snne_pkg::cmd_t cmd,
  output logic                cmd_pop,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [15:0]         out_tdata,
  output logic [1:0]          out_tuser
);

  localparam int NAW   = $clog2(MAX_NODES);
  localparam int LAW   = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
  localparam int AW    = 33 + $clog2(MAX_LINKS);
  localparam int PW    = $clog2(PASSES + 1);
  localparam int TSIZE = 1 << TANH_TABLE_BITS;
  localparam int TSH   = 15 - TANH_TABLE_BITS;
  localparam logic [12:0] LINK_LIM = (MAX_LINKS > 4096) ? 13'd4096 : 13'(MAX_LINKS);

  typedef logic [12:0] rom_t [TSIZE];

  // tanh at bucket midpoints, built at elaboration
  function automatic rom_t build_tanh();
    rom_t        t;
    longint      mid, z, z2, z3, z4, e;
    logic [63:0] num, den, rem, q;
    int          k, m, b;
    for (k = 0; k < TSIZE; k++) begin
      mid = ((64'(2 * k + 1)) << TSH) >> 1;
      z   = mid <<< 11;
      z2  = (z * z) >>> 30;
      z3  = (z2 * z) >>> 30;
      z4  = (z3 * z) >>> 30;
      e   = (64'sd1 <<< 30) - z + z2 / 2 - z3 / 6 + z4 / 24;
      for (m = 0; m < 8; m++) e = (e * e) >>> 30;
      den = 64'((64'sd1 <<< 30) + e);
      num = 64'((((64'sd1 <<< 30) - e) <<< 12) + ((64'sd1 <<< 30) + e) / 2);
      rem = 64'd0;
      q   = 64'd0;
      for (b = 47; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= den) begin
          rem  = rem - den;
          q[b] = 1'b1;
        end
      end
      t[k] = q[12:0];
    end
    return t;
  endfunction

  localparam rom_t TANH_ROM = build_tanh();

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_READ  = 11'b00000000010,
    S_NODE  = 11'b00000000100,
    S_RANGE = 11'b00000001000,
    S_LINKS = 11'b00000010000,
    S_DRAIN = 11'b00000100000,
    S_ROUND = 11'b00001000000,
    S_TANH  = 11'b00010000000,
    S_WB    = 11'b00100000000,
    S_COPY  = 11'b01000000000,
    S_RESP  = 11'b10000000000
  } state_t;

  // storage
  logic [23:0]          link_mem [MAX_LINKS];
  logic [25:0]          rng_mem  [MAX_NODES];
  logic [15:0]          act_mem  [MAX_NODES];
  logic [15:0]          sh_mem   [MAX_NODES];
  logic [MAX_NODES-1:0] act_vld_r;

  state_t               state_r;
  snne_pkg::cmd_t       cur_r;
  logic [12:0]          i_r, j_r, last_r;
  logic [PW-1:0]        pass_r;
  logic signed [AW-1:0] acc_r;
  logic                 v1_r, v2_r, v3_r, cv_r;
  logic [NAW-1:0]       ca_r;
  logic [23:0]          link_q;
  logic [25:0]          rng_q;
  logic [15:0]          act_q, sh_q;
  logic signed [15:0]   w2_r;
  logic                 zero2_r, one2_r, vld2_r;
  logic signed [31:0]   prod_r;
  logic [TANH_TABLE_BITS-1:0] tidx_r;
  logic                 tneg_r;
  logic [12:0]          tval_r;
  logic                 out_valid_r;
  logic [15:0]          out_data_r;
  logic [1:0]           out_stat_r;

  // control signals
  logic                 start, ok;
  logic                 link_we, rng_we, act_we, link_rd, act_rd, rng_rd, sh_rd;
  logic [LAW-1:0]       link_wa, link_ra;
  logic [NAW-1:0]       cmd_na, src_na, act_ra, act_wa, i_na, bi_na;
  logic [15:0]          act_wd;
  logic [7:0]           src;
  logic signed [15:0]   val3;
  logic signed [AW:0]   rnd, qsh;
  logic signed [15:0]   xsat;
  logic [16:0]          xabs, tfull;

  assign start   = (state_r == S_IDLE) && cmd_valid && !out_valid_r;
  assign cmd_pop = start;
  assign ok      = (cmd.status == snne_pkg::STAT_OK);
  assign cmd_na  = NAW'(cmd.index);
  assign i_na    = NAW'(i_r);
  assign bi_na   = NAW'(cnt.bc + 13'(cmd.index));
  assign src     = link_q[23:16];
  assign src_na  = NAW'(12'(src));
  assign link_wa = LAW'(17'(cmd.index));
  assign link_ra = LAW'(17'(j_r));

  assign link_we = start && cmd.req == snne_pkg::REQ_LINK && ok;
  assign rng_we  = start && cmd.req == snne_pkg::REQ_RANGE && ok;
  assign link_rd = (state_r == S_LINKS) && (j_r < last_r);
  assign rng_rd  = (state_r == S_NODE) && (i_r < cnt.nc);
  assign sh_rd   = (state_r == S_COPY) && (i_r < cnt.nc);

  // one shared read port on the activation memory
  assign act_rd  = v1_r || (start && cmd.req == snne_pkg::REQ_READ);
  assign act_ra  = v1_r ? src_na : cmd_na;

  // one shared write port: sensor loads and the copy-back sweep
  always_comb begin
    act_we = 1'b0;
    act_wa = ca_r;
    act_wd = sh_q;
    if (cv_r) begin
      act_we = 1'b1;
    end else if (start && cmd.req == snne_pkg::REQ_SENSOR && ok) begin
      act_we = 1'b1;
      act_wa = bi_na;
      act_wd = cmd.sensor;
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= {cmd.source, cmd.weight};
    if (link_rd) link_q <= link_mem[link_ra];
  end

  always_ff @(posedge clk) begin
    if (rng_we) rng_mem[cmd_na] <= {cmd.rstart, cmd.rend};
    if (rng_rd) rng_q <= rng_mem[i_na];
  end

  always_ff @(posedge clk) begin
    if (act_we) act_mem[act_wa] <= act_wd;
    if (act_rd) act_q <= act_mem[act_ra];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_WB) sh_mem[i_na] <= tneg_r ? 16'(-$signed({3'b000, tval_r}))
                                                 : {3'b000, tval_r};
    if (sh_rd) sh_q <= sh_mem[i_na];
  end

  // node value selection, rounding and saturation
  always_comb begin
    if (zero2_r)      val3 = 16'sd0;
    else if (one2_r)  val3 = snne_pkg::Q_ONE;
    else if (vld2_r)  val3 = act_q;
    else              val3 = 16'sd0;
    rnd = (AW+1)'(acc_r) + (AW+1)'(2048);
    qsh = rnd >>> 12;
    if (qsh > (AW+1)'(32767))        xsat = 16'sd32767;
    else if (qsh < -(AW+1)'(32768))  xsat = -16'sd32768;
    else                             xsat = qsh[15:0];
    xabs  = xsat[15] ? 17'(17'd0 - {xsat[15], xsat}) : {1'b0, xsat};
    tfull = xabs >> TSH;
  end

  // payload pipeline of the multiply-accumulate path
  always_ff @(posedge clk) begin
    w2_r    <= link_q[15:0];
    zero2_r <= 32'(src) >= 32'(cnt.nc);
    one2_r  <= 13'(src) < cnt.bc;
    vld2_r  <= act_vld_r[src_na];
    prod_r  <= w2_r * val3;
    if (state_r == S_RANGE)
      acc_r <= '0;
    else if (v3_r)
      acc_r <= acc_r + AW'(prod_r);
    if (state_r == S_ROUND) begin
      tneg_r <= xsat[15];
      tidx_r <= (32'(tfull) >= TSIZE) ? TANH_TABLE_BITS'(TSIZE - 1)
                                      : TANH_TABLE_BITS'(tfull);
    end
    if (state_r == S_TANH) tval_r <= TANH_ROM[tidx_r];
    if (sh_rd) ca_r <= i_na;
    if (start) cur_r <= cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      act_vld_r   <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      cv_r        <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      last_r      <= '0;
      pass_r      <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
      out_stat_r  <= snne_pkg::STAT_OK;
    end else begin
      v1_r <= link_rd;
      v2_r <= v1_r;
      v3_r <= v2_r;
      cv_r <= sh_rd;
      if (act_we) act_vld_r[act_wa] <= 1'b1;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            case (cmd.req)
              snne_pkg::REQ_READ: begin
                state_r <= S_READ;
              end
              snne_pkg::REQ_ACTIVATE: begin
                i_r     <= cnt.ic;
                pass_r  <= '0;
                state_r <= S_NODE;
              end
              default: begin
                if (cmd.req == snne_pkg::REQ_CLEAR) begin
                  for (int k = 0; k < MAX_NODES; k++)
                    if (32'(k) >= 32'(cnt.ic)) act_vld_r[k] <= 1'b0;
                end
                out_valid_r <= 1'b1;
                out_data_r  <= '0;
                out_stat_r  <= cmd.status;
              end
            endcase
          end
        end
        S_READ: begin
          out_valid_r <= 1'b1;
          out_stat_r  <= cur_r.status;
          if (cur_r.status != snne_pkg::STAT_OK)      out_data_r <= '0;
          else if (13'(cur_r.index) < cnt.bc)         out_data_r <= snne_pkg::Q_ONE;
          else if (act_vld_r[NAW'(cur_r.index)])      out_data_r <= act_q;
          else                                        out_data_r <= '0;
          state_r <= S_IDLE;
        end
        S_NODE: begin
          if (i_r < cnt.nc) begin
            state_r <= S_RANGE;
          end else begin
            i_r     <= cnt.ic;
            state_r <= S_COPY;
          end
        end
        S_RANGE: begin
          j_r     <= rng_q[25:13];
          last_r  <= (rng_q[12:0] > LINK_LIM) ? LINK_LIM : rng_q[12:0];
          state_r <= S_LINKS;
        end
        S_LINKS: begin
          if (j_r < last_r) j_r <= j_r + 13'd1;
          else              state_r <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!v1_r && !v2_r && !v3_r) state_r <= S_ROUND;
        end
        S_ROUND: state_r <= S_TANH;
        S_TANH:  state_r <= S_WB;
        S_WB: begin
          i_r     <= i_r + 13'd1;
          state_r <= S_NODE;
        end
        S_COPY: begin
          if (i_r < cnt.nc) begin
            i_r <= i_r + 13'd1;
          end else if (!cv_r) begin
            if (32'(pass_r) + 1 < PASSES) begin
              pass_r  <= pass_r + PW'(1);
              i_r     <= cnt.ic;
              state_r <= S_NODE;
            end else begin
              state_r <= S_RESP;
            end
          end
        end
        S_RESP: begin
          out_valid_r <= 1'b1;
          out_data_r  <= '0;
          out_stat_r  <= snne_pkg::STAT_OK;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

endmodule
`default_nettype wire

/* src/sparse_neural_net_evaluator_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// writes, range loads, sensor loads and clears answer from idle; reads pass through S_READ
// activate: each computed node reads its range, walks its links, drains the pipe,
//   rounds, looks up tanh and writes back; a copy sweep of computed nodes ends each pass
// throughput: the queue takes one request per cycle until full; execution handles one
//   request at a time, waits while a result is pending, and walks one link per cycle
// reset: synchronous active low; activations read zero but bias nodes read one; config is 1, 1, 1
// ----------------------------------------------------------------------------
// sparse_neural_net_evaluator_top
// sparse network forward pass with saturating tanh in q4.12
// ----------------------------------------------------------------------------
module sparse_neural_net_evaluator_top #(
  parameter int MAX_NODES       = 256,
  parameter int MAX_LINKS       = 4096,
  parameter int PASSES          = 1,
  parameter int TANH_TABLE_BITS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // index[11:0] source_node[19:12] weight[35:20] range_start[48:36]
  // range_end[61:49] sensor_value[77:62] zero pad[79:78]
  input  wire logic [79:0] in_tdata,
  // req_type[2:0]
  input  wire logic [2:0]  in_tuser,
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // read_value[15:0]
  output logic [15:0]      out_tdata,
  // status[1:0]
  output logic [1:0]       out_tuser,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);

  logic [7:0]     bias_count_r;
  logic [8:0]     input_count_r, node_count_r;
  snne_pkg::cnt_t cnt;
  logic           cmd_valid, cmd_pop;
  snne_pkg::cmd_t cmd;

  // config is always taken; index three is ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_count_r  <= 8'd1;
      input_count_r <= 9'd1;
      node_count_r  <= 9'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        snne_pkg::CFG_BIAS:  bias_count_r  <= cfg_data[7:0];
        snne_pkg::CFG_INPUT: input_count_r <= cfg_data;
        snne_pkg::CFG_NODES: node_count_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // effective counts, each clamped by the one above
  always_comb begin
    cnt.nc = (32'(node_count_r) < MAX_NODES) ? 13'(node_count_r) : 13'(MAX_NODES);
    cnt.ic = (13'(input_count_r) < cnt.nc) ? 13'(input_count_r) : cnt.nc;
    cnt.bc = (13'(bias_count_r) < cnt.ic) ? 13'(bias_count_r) : cnt.ic;
  end

  // front: decode, checks and command queue
  snne_front #(
    .MAX_NODES(MAX_NODES),
    .MAX_LINKS(MAX_LINKS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cnt      (cnt),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  // back: storage, evaluation and result register
  snne_back #(
    .MAX_NODES      (MAX_NODES),
    .MAX_LINKS      (MAX_LINKS),
    .PASSES         (PASSES),
    .TANH_TABLE_BITS(TANH_TABLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cnt       (cnt),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
`default_nettype wire

/* src/snne_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snne_checker
// port level checks of the evaluator result channel
// ----------------------------------------------------------------------------
module snne_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // any error result carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != snne_pkg::STAT_OK |-> out_tdata == 16'd0)
    else $error("error result with nonzero value");

  // nothing is offered right after reset
  a_rst: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid)
    else $error("result offered after reset");

endmodule

bind sparse_neural_net_evaluator_top snne_checker u_snne_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
`default_nettype wire
